### rtl/chr_pkg.sv
package chr_pkg;

  localparam int RING_ENTRIES = 64;
  localparam int SHARD_COUNT  = 16;
  localparam int IDX_W        = $clog2(RING_ENTRIES);
  localparam int CNT_W        = $clog2(RING_ENTRIES + 1);
  localparam int SHARD_W      = 4;
  localparam int HASH_W       = 32;
  localparam int HASH_SHIFT   = 15;
  localparam logic [HASH_W-1:0] HASH_MUL = 32'h5bd1e995;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [HASH_W-1:0]  hash;
    logic [SHARD_W-1:0] shard;
  } ring_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_LK_RD,
    S_LK_CMP,
    S_IN_RD,
    S_IN_CMP,
    S_IN_PUT,
    S_RESP
  } state_t;

  function automatic logic [SHARD_W-1:0] clamp_shard(input logic [SHARD_W-1:0] s);
    logic [SHARD_W-1:0] r;
    r = s;
    if (int'(s) >= SHARD_COUNT) begin
      r = SHARD_W'(SHARD_COUNT - 1);
    end
    return r;
  endfunction

endpackage

### rtl/chr_if.sv
interface chr_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [7:0]                   key_byte;
  logic                         last;
  logic [chr_pkg::SHARD_W-1:0]  entry_shard;

  modport source (output valid, mode, key_byte, last, entry_shard, input ready);
  modport sink (input valid, mode, key_byte, last, entry_shard, output ready);
endinterface

interface chr_out_if;
  logic                         valid;
  logic                         ready;
  logic [chr_pkg::SHARD_W-1:0]  target_shard;
  logic [chr_pkg::HASH_W-1:0]   key_hash;
  logic [1:0]                   status;

  modport source (output valid, target_shard, key_hash, status, input ready);
  modport sink (input valid, target_shard, key_hash, status, output ready);
endinterface

### rtl/chr_fold.sv
module chr_fold (
  input  logic                        clk,
  input  logic                        load,
  input  logic [chr_pkg::HASH_W-1:0]  accum,
  input  logic [7:0]                  key_byte,
  output logic [chr_pkg::HASH_W-1:0]  hash
);

  logic [chr_pkg::HASH_W-1:0] x;
  logic [chr_pkg::HASH_W-1:0] m;

  // xor sign-extended byte, multiply next cycle
  always_ff @(posedge clk) begin
    if (load) begin
      x <= accum ^ {{(chr_pkg::HASH_W - 8){key_byte[7]}}, key_byte};
    end
  end

  assign m    = x * chr_pkg::HASH_MUL;
  assign hash = m ^ (m >> chr_pkg::HASH_SHIFT);

endmodule

### rtl/consistent_hash_ring.sv
// handshake: one beat at a time, ready only while idle
// non-final byte: registered in the fold unit, then multiplied and mixed into the accumulator
// final lookup byte: a read and a compare per ring entry scanned up to the first match
// final insert byte: compare per entry from the top, put at bottom; no write when full
// a result still held in the output register stalls the next final byte
// rst (synchronous) clears control, seed, accumulator and entry count; ring contents stay
module consistent_hash_ring (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [chr_pkg::HASH_W-1:0]  cfg_data,
  chr_in_if.sink                      key_in,
  chr_out_if.source                   result
);

  chr_pkg::state_t state, state_next;

  logic [chr_pkg::HASH_W-1:0]  seed;
  logic [chr_pkg::HASH_W-1:0]  accum;
  logic [chr_pkg::HASH_W-1:0]  hash;
  logic [chr_pkg::HASH_W-1:0]  key_h;
  logic [chr_pkg::CNT_W-1:0]   entry_count;
  logic [chr_pkg::CNT_W-1:0]   cnt_m1;
  logic [chr_pkg::IDX_W-1:0]   idx;
  logic [1:0]                  mode_r;
  logic                        last_r;
  logic [chr_pkg::SHARD_W-1:0] shard_r;
  logic [chr_pkg::SHARD_W-1:0] first_shard;
  logic [chr_pkg::SHARD_W-1:0] res_target;
  logic [1:0]                  res_status;

  chr_pkg::ring_entry_t        ring [chr_pkg::RING_ENTRIES];
  chr_pkg::ring_entry_t        rdata;
  chr_pkg::ring_entry_t        wdata;
  logic [chr_pkg::IDX_W-1:0]   waddr;
  logic                        mem_we;

  logic                        accept;
  logic                        fold_load;
  logic                        obuf_load;
  logic                        last_entry;
  logic                        hit;
  logic                        greater;

  logic                        o_valid;
  logic [chr_pkg::SHARD_W-1:0] o_target;
  logic [chr_pkg::HASH_W-1:0]  o_hash;
  logic [1:0]                  o_status;

  assign accept     = key_in.valid && key_in.ready;
  assign cnt_m1     = entry_count - chr_pkg::CNT_W'(1);
  assign last_entry = (chr_pkg::CNT_W'(idx) == cnt_m1);
  assign hit        = (rdata.hash >= key_h);
  assign greater    = (rdata.hash > key_h);

  chr_fold u_fold (
    .clk      (clk),
    .load     (fold_load),
    .accum    (accum),
    .key_byte (key_in.key_byte),
    .hash     (hash)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[waddr] <= wdata;
    end
    rdata <= ring[idx];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      chr_pkg::S_IDLE: begin
        if (accept && (key_in.mode == chr_pkg::MODE_LOOKUP ||
                       key_in.mode == chr_pkg::MODE_INSERT)) begin
          state_next = chr_pkg::S_FOLD;
        end
      end
      chr_pkg::S_FOLD: begin
        if (!last_r) begin
          state_next = chr_pkg::S_IDLE;
        end else if (mode_r == chr_pkg::MODE_LOOKUP) begin
          state_next = (entry_count == '0) ? chr_pkg::S_RESP : chr_pkg::S_LK_RD;
        end else if (int'(entry_count) >= chr_pkg::RING_ENTRIES) begin
          state_next = chr_pkg::S_RESP;
        end else if (entry_count == '0) begin
          state_next = chr_pkg::S_IN_PUT;
        end else begin
          state_next = chr_pkg::S_IN_RD;
        end
      end
      chr_pkg::S_LK_RD:  state_next = chr_pkg::S_LK_CMP;
      chr_pkg::S_LK_CMP: begin
        state_next = (hit || last_entry) ? chr_pkg::S_RESP : chr_pkg::S_LK_RD;
      end
      chr_pkg::S_IN_RD:  state_next = chr_pkg::S_IN_CMP;
      chr_pkg::S_IN_CMP: begin
        if (!greater) begin
          state_next = chr_pkg::S_RESP;
        end else if (idx == '0) begin
          state_next = chr_pkg::S_IN_PUT;
        end else begin
          state_next = chr_pkg::S_IN_RD;
        end
      end
      chr_pkg::S_IN_PUT: state_next = chr_pkg::S_RESP;
      chr_pkg::S_RESP: begin
        if (!o_valid || result.ready) begin
          state_next = chr_pkg::S_IDLE;
        end
      end
      default: state_next = chr_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    key_in.ready = 1'b0;
    fold_load    = 1'b0;
    obuf_load    = 1'b0;
    mem_we       = 1'b0;
    waddr        = idx;
    wdata.hash   = key_h;
    wdata.shard  = shard_r;
    case (state)
      chr_pkg::S_IDLE: begin
        key_in.ready = !rst;
        fold_load    = 1'b1;
      end
      chr_pkg::S_IN_CMP: begin
        mem_we = 1'b1;
        waddr  = idx + chr_pkg::IDX_W'(1);
        if (greater) begin
          wdata = rdata;
        end
      end
      chr_pkg::S_IN_PUT: begin
        mem_we = 1'b1;
      end
      chr_pkg::S_RESP: begin
        obuf_load = !o_valid || result.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= chr_pkg::S_IDLE;
      seed        <= '0;
      accum       <= '0;
      entry_count <= '0;
      o_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        seed  <= cfg_data;
        accum <= cfg_data;
      end
      if (accept && key_in.mode == chr_pkg::MODE_CLEAR) begin
        entry_count <= '0;
        accum       <= seed;
      end
      if (state == chr_pkg::S_FOLD) begin
        accum <= last_r ? seed : hash;
      end
      if ((state == chr_pkg::S_IN_CMP && !greater) || state == chr_pkg::S_IN_PUT) begin
        entry_count <= entry_count + chr_pkg::CNT_W'(1);
      end
      if (obuf_load) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= key_in.mode;
      last_r  <= key_in.last;
      shard_r <= chr_pkg::clamp_shard(key_in.entry_shard);
    end
    case (state)
      chr_pkg::S_FOLD: begin
        key_h      <= hash;
        res_status <= chr_pkg::STATUS_OK;
        if (mode_r == chr_pkg::MODE_LOOKUP) begin
          res_target <= '0;
          idx        <= '0;
          if (entry_count == '0) begin
            res_status <= chr_pkg::STATUS_EMPTY;
          end
        end else begin
          res_target <= shard_r;
          idx        <= (entry_count == '0) ? '0 : cnt_m1[chr_pkg::IDX_W-1:0];
          if (int'(entry_count) >= chr_pkg::RING_ENTRIES) begin
            res_status <= chr_pkg::STATUS_FULL;
          end
        end
      end
      chr_pkg::S_LK_CMP: begin
        if (idx == '0) begin
          first_shard <= rdata.shard;
        end
        if (hit) begin
          res_target <= rdata.shard;
        end else if (last_entry) begin
          res_target <= (idx == '0) ? rdata.shard : first_shard;
        end else begin
          idx <= idx + chr_pkg::IDX_W'(1);
        end
      end
      chr_pkg::S_IN_CMP: begin
        if (greater && idx != '0) begin
          idx <= idx - chr_pkg::IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (obuf_load) begin
      o_target <= res_target;
      o_hash   <= key_h;
      o_status <= res_status;
    end
  end

  assign result.valid        = o_valid;
  assign result.target_shard = o_target;
  assign result.key_hash     = o_hash;
  assign result.status       = o_status;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    int'(entry_count) <= chr_pkg::RING_ENTRIES)
    else $error("entry count above ring size");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && key_in.mode == chr_pkg::MODE_CLEAR |=> entry_count == '0)
    else $error("clear did not empty the ring");

  a_write_on_insert: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mode_r == chr_pkg::MODE_INSERT && last_r))
    else $error("ring written outside an insert");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    accept && !key_in.last && (key_in.mode == chr_pkg::MODE_LOOKUP ||
      key_in.mode == chr_pkg::MODE_INSERT) |=> !key_in.ready ##1 key_in.ready)
    else $error("non-final byte did not take two cycles");

endmodule
